>>> design/assert_macros.svh
// Assertion macros used by the top level of the indexed array list.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge outside reset.
`define IAL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define IAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IAL_ASSERT(lbl, clk, rst, prop, msg)
`define IAL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/ial_pkg.sv
// Package for the indexed array list: field widths, operation and status
// codes, and the command struct that the top level broadcasts to the cells.
// Depends on nothing.
package ial_pkg;

  localparam int MODE_W           = 2;
  localparam int POS_W            = 7;
  localparam int DATA_W           = 32;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 7;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Update command seen by every cell; at most one flag is set.
  typedef struct packed {
    logic append;
    logic insert;
    logic remove;
  } cell_cmd_t;

endpackage

>>> design/ial_req_if.sv
// Request channel of the indexed array list: valid/ready plus one request.
// Depends on ial_pkg for the field widths.
interface ial_req_if import ial_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

>>> design/ial_rsp_if.sv
// Response channel of the indexed array list: valid/ready plus one result.
// Depends on ial_pkg for the field widths.
interface ial_rsp_if import ial_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] read_value;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, status, read_value, count, input ready);
  modport sink   (input valid, status, read_value, count, output ready);
endinterface

>>> design/ial_cell.sv
// One storage cell of the list: holds the entry at a fixed index and takes
// a new value from the request, its lower neighbor or its upper neighbor.
// Depends on ial_pkg.
module ial_cell import ial_pkg::*; #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]  pos,
  input  logic [CNT_W-1:0]  count,
  input  logic [DATA_W-1:0] item_value,
  input  logic [DATA_W-1:0] lower,
  input  logic [DATA_W-1:0] upper,
  output logic [DATA_W-1:0] value,
  output logic [DATA_W-1:0] rd
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.append && (MY_IDX == count)) begin
      value <= item_value;
    end else if (cmd.insert && (MY_IDX == pos)) begin
      value <= item_value;
    end else if (cmd.insert && (MY_IDX > pos)) begin
      value <= lower;
    end else if (cmd.remove && (MY_IDX >= pos)) begin
      value <= upper;
    end
  end

  // Masked read: only the addressed cell drives nonzero data.
  assign rd = (MY_IDX == pos) ? value : '0;

endmodule

>>> design/indexed_array_list.sv
// Top level of the indexed array list: a row of storage cells, the request
// decode with status checks, and the registered response stage.
// Depends on ial_pkg, ial_req_if, ial_rsp_if, ial_cell and assert_macros.svh.
//
//   channel  role    beat contents
//   -------  ------  ---------------------------------
//   req      sink    mode, position, item_value
//   rsp      source  status, read_value, count
//
// Every request beat produces exactly one response beat in the following
// cycle. All entries move at once: an insert shifts every cell above the
// position up by one and a delete shifts every cell at or above it down
// by one. Reset empties the list and the response register at once; the
// stored entries themselves are not cleared because none is read before
// written. A stalled response holds its beat; a new request is taken in
// the same cycle that the held beat leaves.
`include "assert_macros.svh"

module indexed_array_list import ial_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic        clk,
  input logic        rst,
  ial_req_if.sink    req,
  ial_rsp_if.source  rsp
);

  // The count must hold CAPACITY itself and be at least as wide as a position.
  localparam int CAP_BITS = $clog2(CAPACITY + 1);
  localparam int CNT_W    = (CAP_BITS > POS_W) ? CAP_BITS : POS_W;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  pos;
  logic              accept;
  mode_t             mode;
  status_t           status_next;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] rd_any;
  logic [DATA_W-1:0] read_next;

  logic [DATA_W-1:0] vals    [CAPACITY];
  logic [DATA_W-1:0] cell_rd [CAPACITY];

  logic              rsp_valid;
  status_t           rsp_status;
  logic [DATA_W-1:0] rsp_read;
  logic [COUNT_W-1:0] rsp_count;

  // A request enters whenever the response register is empty or draining.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign mode      = mode_t'(req.mode);
  assign pos       = CNT_W'(req.position);

  // Status checks follow the list rules: an insert checks its position
  // before fullness, and a delete reports an empty list before its position.
  always_comb begin
    status_next = ST_OK;
    case (mode)
      MODE_APPEND: begin
        if (cnt >= CAP_C) status_next = ST_FULL;
      end
      MODE_INSERT: begin
        if (pos > cnt) status_next = ST_INDEX;
        else if (cnt >= CAP_C) status_next = ST_FULL;
      end
      MODE_DELETE: begin
        if (cnt == '0) status_next = ST_EMPTY;
        else if (pos >= cnt) status_next = ST_INDEX;
      end
      MODE_GET: begin
        if (pos >= cnt) status_next = ST_INDEX;
      end
      default: begin
        status_next = ST_INDEX;
      end
    endcase
  end

  // Only an accepted, successful request moves the cells or the count.
  always_comb begin
    cmd        = '0;
    cmd.append = accept && (status_next == ST_OK) && (mode == MODE_APPEND);
    cmd.insert = accept && (status_next == ST_OK) && (mode == MODE_INSERT);
    cmd.remove = accept && (status_next == ST_OK) && (mode == MODE_DELETE);
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.append || cmd.insert) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.remove) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  // The row of cells. Each cell sees its two neighbors; the ends are tied off.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = vals[i];
    end else begin : g_upper
      assign upper = vals[i+1];
    end

    ial_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .count      (cnt),
      .item_value (req.item_value),
      .lower      (lower),
      .upper      (upper),
      .value      (vals[i]),
      .rd         (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so an OR collects it.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  assign read_next = ((mode == MODE_GET) && (status_next == ST_OK)) ? rd_any : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload needs no reset; it is only looked at while valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_read   <= read_next;
      rsp_count  <= cnt_next[COUNT_W-1:0];
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = rsp_read;
  assign rsp.count      = rsp_count;

  // The list never holds more entries than the row has cells.
  `IAL_ASSERT(a_cnt_bound, clk, rst, cnt <= CAP_C, "entry count above capacity")
  // The count moves only when a request is taken.
  `IAL_ASSERT(a_cnt_idle, clk, rst, !accept |=> $stable(cnt), "count moved without a request")
  // A rejected request leaves the count untouched.
  `IAL_ASSERT(a_err_hold, clk, rst, (accept && status_next != ST_OK) |=> cnt == $past(cnt), "count moved on a rejected request")
  // Read data is zero for everything except a successful get.
  `IAL_ASSERT(a_rd_zero, clk, rst, (rsp_valid && rsp_status != ST_OK) |-> rsp_read == '0, "nonzero read data on an error")
  // Reset empties the response stage.
  `IAL_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "response valid after reset")

endmodule
